FILE: hw/rtl/pbkd_pkg.sv
// ----------------------------------------------------------------------------
// pbkd_pkg: shared types and constants for the key derivation block
// Payload structs, the controller's commands and states, and SHA-256 tables.
// ----------------------------------------------------------------------------
package pbkd_pkg;

  localparam int MaxPassBytesDefault = 64;
  localparam logic [23:0] IterResetValue = 24'd300000;
  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5c;

  localparam logic [2:0] CfgSalt0 = 3'd0;
  localparam logic [2:0] CfgSalt1 = 3'd1;
  localparam logic [2:0] CfgSalt2 = 3'd2;
  localparam logic [2:0] CfgSalt3 = 3'd3;
  localparam logic [2:0] CfgIter  = 3'd4;

  typedef struct packed {
    logic [7:0] pass_byte;
    logic       byte_valid;
    logic       pass_last;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] key_word;
    logic [1:0]  word_index;
    logic        key_last;
    logic        pass_overflow;
  } out_beat_t;

  // source of the byte fed into the message block
  typedef enum logic [2:0] {
    SRC_KEY,      // u xor pad
    SRC_PAD,      // pad byte alone
    SRC_PASS,     // passphrase buffer
    SRC_DIGEST,   // inner digest
    SRC_FINAL     // 0x80, zeros and length
  } byte_src_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROUND_START,
    ST_FEED,
    ST_COMPRESS,
    ST_HASH_DONE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic       init_derive;   // u = salt, acc = 0
    logic       sha_begin;     // load initial hash, clear block fill
    logic       feed;          // push one byte
    byte_src_t  src;
    logic [5:0] idx;           // byte index within source
    logic       comp_start;
    logic       save_inner;
    logic       save_outer;    // u = digest, acc ^= digest
  } dp_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       comp_busy;
    logic [5:0] fill;
  } dp_stat_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: hw/rtl/pbkdf2_hmac_sha256_key_derive.sv
// ----------------------------------------------------------------------------
// pbkdf2_hmac_sha256_key_derive: passphrase-based key derivation
// Stores passphrase bytes, then folds iterated hmac-sha256 of the salt into
// a 256-bit key sent out as four 64-bit beats.
// ----------------------------------------------------------------------------
//   channel   signals                         dir   beat
//   in        in_valid in_stall in_data       in    one passphrase byte
//   out       out_valid out_stall out_data    out   one 64-bit key word
//   cfg       cfg_we cfg_index cfg_data       in    salt words, iteration count
//
// loading takes one beat per cycle; after a last beat input is stalled
// while each hmac round runs four sha blocks on one round-per-cycle
// compressor, and one block more once the passphrase reaches 56 bytes;
// a zero iteration count goes straight to the key beats, which then leave
// one per cycle as long as out_stall is low. reset is synchronous and
// restores the registers and an empty passphrase.
module pbkdf2_hmac_sha256_key_derive #(
  parameter int MaxPassBytes = pbkd_pkg::MaxPassBytesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbkd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pbkd_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  localparam int LenW = $clog2(MaxPassBytes+1);
  localparam int AddrW = $clog2(MaxPassBytes);

  logic [63:0] salt [4];
  logic [23:0] iter_count;
  logic [LenW-1:0] pass_len;
  logic [LenW+2:0] pass_bits;
  logic        ovf;
  logic        loading, accept, out_taken, emit_valid;
  logic [1:0]  emit_index;
  logic        store;
  pbkd_pkg::dp_cmd_t  cmd;
  pbkd_pkg::dp_stat_t stat;
  logic        comp_done;
  logic [255:0] key_acc;
  logic [AddrW-1:0] pass_raddr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) salt[i] <= '0;
      iter_count <= pbkd_pkg::IterResetValue;
    end else if (cfg_we) begin
      case (cfg_index)
        pbkd_pkg::CfgSalt0: salt[0] <= cfg_data;
        pbkd_pkg::CfgSalt1: salt[1] <= cfg_data;
        pbkd_pkg::CfgSalt2: salt[2] <= cfg_data;
        pbkd_pkg::CfgSalt3: salt[3] <= cfg_data;
        pbkd_pkg::CfgIter:  iter_count <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !loading;
  assign accept = in_valid && !in_stall;
  assign store = accept && in_data.byte_valid && (pass_len < LenW'(MaxPassBytes));
  assign out_valid = emit_valid;
  assign out_taken = out_valid && !out_stall;
  assign pass_bits = {pass_len, 3'b000};

  // passphrase length and overflow; clear after the last key beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_len <= '0;
      ovf <= 1'b0;
    end else if (out_taken && emit_index == 2'd3) begin
      pass_len <= '0;
      ovf <= 1'b0;
    end else if (accept && in_data.byte_valid) begin
      if (store) pass_len <= pass_len + LenW'(1);
      else ovf <= 1'b1;
    end
  end

  pbkd_ctrl #(.MaxPassBytes(MaxPassBytes)) u_ctrl (
    .clk(clk), .rst(rst), .start(accept && in_data.pass_last),
    .pass_len(pass_len), .iter_count(iter_count), .stat(stat), .comp_done(comp_done),
    .out_taken(out_taken), .cmd(cmd), .pass_raddr(pass_raddr), .loading(loading),
    .emit_valid(emit_valid), .emit_index(emit_index)
  );

  pbkd_datapath #(.MaxPassBytes(MaxPassBytes)) u_dp (
    .clk(clk), .rst(rst), .load_we(store), .load_addr(pass_len[AddrW-1:0]),
    .load_byte(in_data.pass_byte), .pass_raddr(pass_raddr),
    .salt({salt[0], salt[1], salt[2], salt[3]}),
    .pass_bits_len(pass_bits), .cmd(cmd), .stat(stat),
    .comp_done(comp_done), .key_acc(key_acc)
  );

  // key word out of the accumulator, word 0 holds the top bits
  always_comb begin
    out_data.key_word = key_acc[255 - 64*emit_index -: 64];
    out_data.word_index = emit_index;
    out_data.key_last = (emit_index == 2'd3);
    out_data.pass_overflow = ovf;
  end

`ifndef ASSERT_OFF
  // no passphrase beat is taken while key beats are pending
  assert property (@(posedge clk) disable iff (rst) !(accept && out_valid))
    else $error("input accepted during key output");
  // the key index only moves on a taken beat
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (emit_index == $past(emit_index)))
    else $error("key index moved under stall");
  // stored length never exceeds the buffer
  assert property (@(posedge clk) disable iff (rst) pass_len <= LenW'(MaxPassBytes))
    else $error("passphrase length beyond buffer");
`endif
endmodule

FILE: hw/rtl/pbkd_ram.sv
// ----------------------------------------------------------------------------
// pbkd_ram: generic simple dual-port ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pbkd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/pbkd_compress.sv
// ----------------------------------------------------------------------------
// pbkd_compress: sha-256 compression, one round per cycle
// Takes a 512-bit block and chaining value; 64 rounds then the final add.
// ----------------------------------------------------------------------------
module pbkd_compress (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] block,
  input  logic [255:0] h_in,
  output logic         busy,
  output logic         done,
  output logic [255:0] h_out
);
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [255:0] h_keep;
  logic [5:0]  rnd;
  logic        last_rnd;
  logic [31:0] t1, t2, wt, s0, s1, wnew;

  always_comb begin
    wt = w[0];
    s0 = pbkd_pkg::rotr(w[1], 7) ^ pbkd_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = pbkd_pkg::rotr(w[14], 17) ^ pbkd_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = s1 + w[9] + s0 + w[0];
    t1 = v[7] + (pbkd_pkg::rotr(v[4], 6) ^ pbkd_pkg::rotr(v[4], 11) ^ pbkd_pkg::rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + pbkd_pkg::RoundK[rnd] + wt;
    t2 = (pbkd_pkg::rotr(v[0], 2) ^ pbkd_pkg::rotr(v[0], 13) ^ pbkd_pkg::rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      last_rnd <= 1'b0;
      done <= 1'b0;
      rnd <= '0;
    end else begin
      done <= last_rnd;
      last_rnd <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        rnd <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          last_rnd <= 1'b1;
        end
      end
    end
  end

  // datapath: w is a 16-deep shift line, w[0] is the current round word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      h_keep <= h_in;
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= h_in[255 - 32*i -: 32];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
    if (last_rnd) begin
      for (int i = 0; i < 8; i++) h_out[255 - 32*i -: 32] <= h_keep[255 - 32*i -: 32] + v[i];
    end
  end
endmodule

FILE: hw/rtl/pbkd_datapath.sv
// ----------------------------------------------------------------------------
// pbkd_datapath: passphrase store, message block builder, hmac state
// Runs the commands of the controller byte by byte into a 64-byte block.
// ----------------------------------------------------------------------------
module pbkd_datapath #(
  parameter int MaxPassBytes = pbkd_pkg::MaxPassBytesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_we,
  input  logic [$clog2(MaxPassBytes)-1:0] load_addr,
  input  logic [7:0]                    load_byte,
  input  logic [$clog2(MaxPassBytes)-1:0] pass_raddr,
  input  logic [255:0]                  salt,
  input  logic [$clog2(MaxPassBytes+1)+2:0] pass_bits_len,
  input  pbkd_pkg::dp_cmd_t             cmd,
  output pbkd_pkg::dp_stat_t            stat,
  output logic                          comp_done,
  output logic [255:0]                  key_acc
);
  logic [7:0]   pass_rd;
  logic [511:0] block;
  logic [5:0]   fill;
  logic         full;
  logic [255:0] u_val, inner, h_state, h_new;
  logic [255:0] h_state_acc;
  logic [7:0]   fb;
  logic         busy;

  pbkd_ram #(.Width(8), .Depth(MaxPassBytes)) u_buf (
    .clk(clk), .we(load_we), .waddr(load_addr), .wdata(load_byte),
    .raddr(pass_raddr), .rdata(pass_rd)
  );

  pbkd_compress u_comp (
    .clk(clk), .rst(rst), .start(cmd.comp_start), .block(block), .h_in(h_state),
    .busy(busy), .done(comp_done), .h_out(h_new)
  );

  always_comb begin
    case (cmd.src)
      pbkd_pkg::SRC_KEY: fb = u_val[255 - 8*cmd.idx[4:0] -: 8] ^ pbkd_pkg::IpadByte;
      pbkd_pkg::SRC_PAD: fb = pbkd_pkg::IpadByte;
      pbkd_pkg::SRC_PASS: fb = pass_rd;
      pbkd_pkg::SRC_DIGEST: fb = inner[255 - 8*cmd.idx[4:0] -: 8];
      pbkd_pkg::SRC_FINAL: fb = 8'h00;
      default: fb = 8'h00;
    endcase
  end

  // idx[5] selects the outer pad when set
  logic [7:0] fbyte;
  always_comb begin
    fbyte = fb;
    if (cmd.src == pbkd_pkg::SRC_KEY && cmd.idx[5]) begin
      fbyte = u_val[255 - 8*cmd.idx[4:0] -: 8] ^ pbkd_pkg::OpadByte;
    end else if (cmd.src == pbkd_pkg::SRC_PAD && cmd.idx[5]) begin
      fbyte = pbkd_pkg::OpadByte;
    end else if (cmd.src == pbkd_pkg::SRC_FINAL) begin
      // idx[0]: 0x80 marker, idx[1]: length tail, else zero
      if (cmd.idx[0]) fbyte = 8'h80;
      else fbyte = 8'h00;
    end
  end

  // length field bits: inner = 512 + pass bits, outer = 768
  logic [63:0] len_bits;
  assign len_bits = cmd.idx[5] ? 64'd768 : (64'd512 + 64'(pass_bits_len));

  assign stat.block_full = full;
  assign stat.comp_busy = busy | cmd.comp_start;
  assign stat.fill = fill;
  assign key_acc = h_state_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      full <= 1'b0;
    end else if (cmd.sha_begin || cmd.comp_start) begin
      fill <= '0;
      full <= 1'b0;
    end else if (cmd.feed) begin
      fill <= fill + 6'd1;
      full <= (fill == 6'd63);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed) begin
      if (cmd.src == pbkd_pkg::SRC_FINAL && cmd.idx[1]) begin
        block[63:0] <= len_bits;
      end else begin
        block[511 - 8*fill -: 8] <= fbyte;
      end
    end
    if (cmd.sha_begin) begin
      for (int i = 0; i < 8; i++) h_state[255 - 32*i -: 32] <= pbkd_pkg::InitH[i];
    end else if (comp_done) begin
      h_state <= h_new;
    end
    if (cmd.init_derive) begin
      u_val <= salt;
      h_state_acc <= '0;
    end else if (cmd.save_outer) begin
      u_val <= h_state;
      h_state_acc <= h_state_acc ^ h_state;
    end
    if (cmd.save_inner) begin
      inner <= h_state;
    end
  end
endmodule

FILE: hw/rtl/pbkd_ctrl.sv
// ----------------------------------------------------------------------------
// pbkd_ctrl: sequencer for loading, hmac rounds and key output
// Walks each sha pass byte by byte and hands blocks to the compressor.
// ----------------------------------------------------------------------------
module pbkd_ctrl #(
  parameter int MaxPassBytes = pbkd_pkg::MaxPassBytesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [$clog2(MaxPassBytes+1)-1:0] pass_len,
  input  logic [23:0]          iter_count,
  input  pbkd_pkg::dp_stat_t   stat,
  input  logic                 comp_done,
  input  logic                 out_taken,
  output pbkd_pkg::dp_cmd_t    cmd,
  output logic [$clog2(MaxPassBytes)-1:0] pass_raddr,
  output logic                 loading,
  output logic                 emit_valid,
  output logic [1:0]           emit_index
);
  localparam int LenW = $clog2(MaxPassBytes+1);
  // byte counter also covers the 32-byte key, pad and digest runs
  localparam int CntW = (LenW > 6) ? LenW : 6;

  // phases within one sha pass
  localparam logic [2:0] PhKey = 3'd0;
  localparam logic [2:0] PhPad = 3'd1;
  localparam logic [2:0] PhMsg = 3'd2;
  localparam logic [2:0] PhMark = 3'd3;
  localparam logic [2:0] PhZero = 3'd4;
  localparam logic [2:0] PhLen = 3'd5;

  pbkd_pkg::ctrl_state_t state, state_next;
  logic [2:0]  phase, phase_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic        outer, outer_next;
  logic [23:0] iter, iter_next;
  logic [1:0]  widx, widx_next;
  logic        prefetch, prefetch_next;
  logic [CntW-1:0] msg_len;

  assign msg_len = outer ? CntW'(32) : CntW'(pass_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbkd_pkg::ST_LOAD;
      phase <= PhKey;
      cnt <= '0;
      outer <= 1'b0;
      iter <= '0;
      widx <= '0;
      prefetch <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt <= cnt_next;
      outer <= outer_next;
      iter <= iter_next;
      widx <= widx_next;
      prefetch <= prefetch_next;
    end
  end

  assign pass_raddr = cnt[$clog2(MaxPassBytes)-1:0];
  assign loading = (state == pbkd_pkg::ST_LOAD);
  assign emit_valid = (state == pbkd_pkg::ST_EMIT);
  assign emit_index = widx;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_next = cnt;
    outer_next = outer;
    iter_next = iter;
    widx_next = widx;
    prefetch_next = 1'b0;
    cmd = '0;
    cmd.src = pbkd_pkg::SRC_KEY;
    case (state)
      pbkd_pkg::ST_LOAD: begin
        if (start) begin
          cmd.init_derive = 1'b1;
          iter_next = '0;
          outer_next = 1'b0;
          state_next = (iter_count == 24'd0) ? pbkd_pkg::ST_EMIT : pbkd_pkg::ST_ROUND_START;
          widx_next = '0;
        end
      end
      pbkd_pkg::ST_ROUND_START: begin
        cmd.sha_begin = 1'b1;
        phase_next = PhKey;
        cnt_next = '0;
        state_next = pbkd_pkg::ST_FEED;
      end
      pbkd_pkg::ST_FEED: begin
        if (stat.block_full) begin
          cmd.comp_start = 1'b1;
          state_next = pbkd_pkg::ST_COMPRESS;
        end else begin
          cmd.idx = {outer, 5'(cnt)};
          case (phase)
            PhKey: begin
              cmd.feed = 1'b1;
              cmd.src = pbkd_pkg::SRC_KEY;
              cnt_next = cnt + CntW'(1);
              if (cnt == CntW'(31)) begin
                phase_next = PhPad;
                cnt_next = '0;
              end
            end
            PhPad: begin
              cmd.feed = 1'b1;
              cmd.src = pbkd_pkg::SRC_PAD;
              cnt_next = cnt + CntW'(1);
              if (cnt == CntW'(31)) begin
                phase_next = PhMsg;
                cnt_next = '0;
              end
            end
            PhMsg: begin
              if (cnt == msg_len) begin
                phase_next = PhMark;
              end else if (!outer && !prefetch) begin
                // ram read is registered: wait for the byte before feeding it
                prefetch_next = 1'b1;
              end else begin
                cmd.feed = 1'b1;
                cmd.src = outer ? pbkd_pkg::SRC_DIGEST : pbkd_pkg::SRC_PASS;
                cnt_next = cnt + CntW'(1);
              end
            end
            PhMark: begin
              cmd.feed = 1'b1;
              cmd.src = pbkd_pkg::SRC_FINAL;
              cmd.idx = {outer, 5'd1};
              phase_next = PhZero;
            end
            PhZero: begin
              if (stat.fill == 6'd56) begin
                phase_next = PhLen;
              end else begin
                cmd.feed = 1'b1;
                cmd.src = pbkd_pkg::SRC_FINAL;
                cmd.idx = {outer, 5'd0};
              end
            end
            PhLen: begin
              // 8-byte length rewritten on each of the last eight slots until full
              cmd.feed = 1'b1;
              cmd.src = pbkd_pkg::SRC_FINAL;
              cmd.idx = {outer, 5'd2};
            end
            default: phase_next = PhKey;
          endcase
        end
      end
      pbkd_pkg::ST_COMPRESS: begin
        if (comp_done) begin
          if (phase == PhLen) state_next = pbkd_pkg::ST_HASH_DONE;
          else state_next = pbkd_pkg::ST_FEED;
        end
      end
      pbkd_pkg::ST_HASH_DONE: begin
        if (!outer) begin
          cmd.save_inner = 1'b1;
          outer_next = 1'b1;
          state_next = pbkd_pkg::ST_ROUND_START;
        end else begin
          cmd.save_outer = 1'b1;
          outer_next = 1'b0;
          iter_next = iter + 24'd1;
          state_next = (iter + 24'd1 == iter_count) ? pbkd_pkg::ST_EMIT
                                                    : pbkd_pkg::ST_ROUND_START;
        end
      end
      pbkd_pkg::ST_EMIT: begin
        if (out_taken) begin
          widx_next = widx + 2'd1;
          if (widx == 2'd3) state_next = pbkd_pkg::ST_LOAD;
        end
      end
      default: state_next = pbkd_pkg::ST_LOAD;
    endcase
  end
endmodule
